// File: rtl/core/ppc_pkg.sv
// Shared types, constants and helper functions for the planar pose composition block.
package ppc_pkg;

    // Default and maximum number of CORDIC rotation cells.
    localparam int TRIG_STAGES_DEF = 24;
    localparam int MAX_STAGES      = 30;

    // Packed stream widths, padded to whole bytes.
    localparam int S_TDATA_W = 192;
    localparam int M_TDATA_W = 224;

    // Width of the CORDIC x, y and residual angle datapath.
    localparam int ROT_W = 33;

    localparam logic signed [ROT_W-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [ROT_W-1:0] Q30_ONE     = 33'sd1073741824;
    localparam logic signed [33:0]      HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0]      PI_Q30      = 34'sd3373259426;
    localparam logic signed [31:0]      PI_Q28      = 32'sd843314857;
    localparam logic signed [31:0]      TWO_PI_Q28  = 32'sd1686629713;
    localparam logic signed [63:0]      ROUND_HALF  = 64'sd536870912;

    // Values that travel alongside the rotation through the cell chain.
    typedef struct packed {
        logic signed [31:0] base_x;
        logic signed [31:0] base_y;
        logic signed [31:0] step_x;
        logic signed [31:0] step_y;
        logic signed [30:0] heading;
        logic               flip;
    } ppc_carry_t;

    // State held by one CORDIC cell.
    typedef struct packed {
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic signed [ROT_W-1:0] z;
    } ppc_rot_t;

    // One finished result beat.
    typedef struct packed {
        logic signed [31:0] sin_base;
        logic signed [31:0] cos_base;
        logic signed [31:0] jac_y_heading;
        logic signed [31:0] jac_x_heading;
        logic signed [30:0] sum_heading;
        logic signed [31:0] sum_y;
        logic signed [31:0] sum_x;
    } ppc_result_t;

    // Truncated Q2.30 arctangent of 2^-idx.
    function automatic logic [31:0] atan_q30(input int unsigned idx);
        logic [31:0] val;
        val = 32'd0;
        unique case (idx)
            0:  val = 32'd843314856;
            1:  val = 32'd497837829;
            2:  val = 32'd263043836;
            3:  val = 32'd133525158;
            4:  val = 32'd67021686;
            5:  val = 32'd33543515;
            6:  val = 32'd16775850;
            7:  val = 32'd8388437;
            8:  val = 32'd4194282;
            9:  val = 32'd2097149;
            10: val = 32'd1048575;
            11: val = 32'd524287;
            12: val = 32'd262143;
            13: val = 32'd131071;
            14: val = 32'd65535;
            15: val = 32'd32767;
            16: val = 32'd16383;
            17: val = 32'd8191;
            18: val = 32'd4095;
            19: val = 32'd2047;
            20: val = 32'd1023;
            21: val = 32'd511;
            22: val = 32'd255;
            23: val = 32'd127;
            24: val = 32'd63;
            25: val = 32'd31;
            26: val = 32'd15;
            27: val = 32'd7;
            28: val = 32'd3;
            29: val = 32'd1;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

    // Saturate a 35-bit signed value to the 32-bit signed range.
    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] res;
        if (v > 35'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end
        else if (v < -35'sd2147483648) begin
            res = 32'sh8000_0000;
        end
        else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

// File: rtl/core/planar_pose_composition.sv
// Top level of the planar pose composition pipeline with its stream ports.
//
// The block composes a base pose with an increment pose given in the base frame.
// Input beats arrive on the s_axis channel, one pose pair per beat; each accepted
// beat yields exactly one result beat on the m_axis channel, in order.
// The base heading is folded into [-pi/2, pi/2] in a prepare stage and then runs
// through a row of TRIG_STAGES CORDIC cells, one cell per rotation step, each
// passing its x, y and residual angle to the next cell whenever the pipeline advances.
// Behind the chain sit a clamp stage, a product stage and a rounding stage; the
// final add and saturation feed the output register.
// m_axis_tvalid rises once the beat has passed the prepare, cell, clamp, product,
// rounding and output registers. It takes one beat per cycle while the skid is empty.
// A skid register behind the output register absorbs the one beat that is still
// produced when the receiver stalls; while it is full the whole pipeline holds
// and s_axis_tready is low. s_axis_tready comes straight from a flip-flop.
// Reset clears all valid bits, so both channels come up empty and the block is
// ready to accept a beat as soon as reset is released.
module planar_pose_composition #(
    parameter int TRIG_STAGES = ppc_pkg::TRIG_STAGES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // Fields from bit 0 up: base_x[31:0], base_y[63:32], base_heading[94:64],
    // step_x[126:95], step_y[158:127], step_heading[189:159], zero padding.
    input  logic [ppc_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // Fields from bit 0 up: sum_x[31:0], sum_y[63:32], sum_heading[94:64],
    // jac_x_heading[126:95], jac_y_heading[158:127], cos_base[190:159],
    // sin_base[222:191], zero padding.
    output logic [ppc_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    // Pipeline advance enable: the pipeline holds only while the skid is full.
    logic en;

    // Input field views.
    logic signed [31:0] base_x, base_y, step_x, step_y;
    logic signed [30:0] base_heading, step_heading;

    // Prepare stage.
    logic                prep_valid_reg;
    ppc_pkg::ppc_rot_t   prep_rot_reg, prep_rot_next;
    ppc_pkg::ppc_carry_t prep_carry_reg, prep_carry_next;
    logic signed [33:0]  z_wide;
    logic signed [31:0]  h_sum;

    // Cell chain links; index 0 is the prepare stage output.
    logic                chain_valid [0:TRIG_STAGES];
    ppc_pkg::ppc_rot_t   chain_rot   [0:TRIG_STAGES];
    ppc_pkg::ppc_carry_t chain_carry [0:TRIG_STAGES];

    // Back end and output buffering.
    logic                 res_valid;
    ppc_pkg::ppc_result_t res;
    logic                 out_valid_reg, out_valid_next;
    ppc_pkg::ppc_result_t out_data_reg, out_data_next;
    logic                 skid_valid_reg, skid_valid_next;
    ppc_pkg::ppc_result_t skid_data_reg;
    logic                 produce;

    assign base_x       = s_axis_tdata[31:0];
    assign base_y       = s_axis_tdata[63:32];
    assign base_heading = s_axis_tdata[94:64];
    assign step_x       = s_axis_tdata[126:95];
    assign step_y       = s_axis_tdata[158:127];
    assign step_heading = s_axis_tdata[189:159];

    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    // Fold the heading (taken to Q2.30) into [-pi/2, pi/2]; a fold by pi
    // negates the sine and cosine, which the back end undoes. The heading
    // sum is wrapped into [-pi, pi] here as well.
    always_comb
    begin
        z_wide = {base_heading[30], base_heading, 2'b00};
        prep_carry_next.flip = 1'b0;
        prep_rot_next.x = ppc_pkg::CORDIC_GAIN;
        prep_rot_next.y = '0;
        if (z_wide > ppc_pkg::HALF_PI_Q30) begin
            prep_rot_next.z = 33'(z_wide - ppc_pkg::PI_Q30);
            prep_carry_next.flip = 1'b1;
        end
        else if (z_wide < -ppc_pkg::HALF_PI_Q30) begin
            prep_rot_next.z = 33'(z_wide + ppc_pkg::PI_Q30);
            prep_carry_next.flip = 1'b1;
        end
        else begin
            prep_rot_next.z = 33'(z_wide);
        end

        h_sum = {base_heading[30], base_heading} + {step_heading[30], step_heading};
        if (h_sum > ppc_pkg::PI_Q28) begin
            prep_carry_next.heading = 31'(h_sum - ppc_pkg::TWO_PI_Q28);
        end
        else if (h_sum < -ppc_pkg::PI_Q28) begin
            prep_carry_next.heading = 31'(h_sum + ppc_pkg::TWO_PI_Q28);
        end
        else begin
            prep_carry_next.heading = 31'(h_sum);
        end
        prep_carry_next.base_x = base_x;
        prep_carry_next.base_y = base_y;
        prep_carry_next.step_x = step_x;
        prep_carry_next.step_y = step_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            prep_valid_reg <= 1'b0;
        end
        else if (en) begin
            prep_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            prep_rot_reg   <= prep_rot_next;
            prep_carry_reg <= prep_carry_next;
        end
    end

    assign chain_valid[0] = prep_valid_reg;
    assign chain_rot[0]   = prep_rot_reg;
    assign chain_carry[0] = prep_carry_reg;

    // The row of CORDIC cells, cell i shifting by i.
    for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_cell
        ppc_cordic_cell #(
            .SHIFT (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (chain_valid[i]),
            .in_rot    (chain_rot[i]),
            .in_carry  (chain_carry[i]),
            .out_valid (chain_valid[i+1]),
            .out_rot   (chain_rot[i+1]),
            .out_carry (chain_carry[i+1])
        );
    end

    ppc_rotate u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (chain_valid[TRIG_STAGES]),
        .in_x      (chain_rot[TRIG_STAGES].x),
        .in_y      (chain_rot[TRIG_STAGES].y),
        .in_carry  (chain_carry[TRIG_STAGES]),
        .out_valid (res_valid),
        .out_res   (res)
    );

    // Output register with a one-beat skid behind it.
    assign produce = res_valid && en;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        if (out_valid_reg && !m_axis_tready) begin
            // Receiver stalls: a newly finished beat parks in the skid.
            if (produce) begin
                skid_valid_next = 1'b1;
            end
        end
        else if (skid_valid_reg) begin
            out_valid_next  = 1'b1;
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end
        else begin
            out_valid_next = produce;
            if (produce) begin
                out_data_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (produce && out_valid_reg && !m_axis_tready) begin
            skid_data_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_data_reg};

    // The skid fills only when the output beat was held by the receiver.
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("skid filled while output was free");

    // The skid never holds a beat while the output register is empty.
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> m_axis_tvalid)
        else $error("skid holds a beat ahead of an empty output");

    // Cosine and sine leave clamped to plus or minus one in Q2.30.
    a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            ($signed(m_axis_tdata[190:159]) <= 32'sd1073741824) &&
            ($signed(m_axis_tdata[190:159]) >= -32'sd1073741824) &&
            ($signed(m_axis_tdata[222:191]) <= 32'sd1073741824) &&
            ($signed(m_axis_tdata[222:191]) >= -32'sd1073741824))
        else $error("cosine or sine out of range");

endmodule

// File: rtl/core/ppc_cordic_cell.sv
// One rotation-mode CORDIC cell with its side data register.
module ppc_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  ppc_pkg::ppc_rot_t   in_rot,
    input  ppc_pkg::ppc_carry_t in_carry,
    output logic                out_valid,
    output ppc_pkg::ppc_rot_t   out_rot,
    output ppc_pkg::ppc_carry_t out_carry
);

    localparam logic signed [ppc_pkg::ROT_W-1:0] ATAN =
        $signed({1'b0, ppc_pkg::atan_q30(SHIFT)});

    logic                valid_reg;
    ppc_pkg::ppc_rot_t   rot_reg;
    ppc_pkg::ppc_rot_t   rot_next;
    ppc_pkg::ppc_carry_t carry_reg;

    logic signed [ppc_pkg::ROT_W-1:0] x_sh;
    logic signed [ppc_pkg::ROT_W-1:0] y_sh;

    always_comb
    begin
        x_sh = in_rot.x >>> SHIFT;
        y_sh = in_rot.y >>> SHIFT;
        // Rotate toward zero residual angle; zero counts as positive.
        if (!in_rot.z[ppc_pkg::ROT_W-1]) begin
            rot_next.x = in_rot.x - y_sh;
            rot_next.y = in_rot.y + x_sh;
            rot_next.z = in_rot.z - ATAN;
        end
        else begin
            rot_next.x = in_rot.x + y_sh;
            rot_next.y = in_rot.y - x_sh;
            rot_next.z = in_rot.z + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            rot_reg   <= rot_next;
            carry_reg <= in_carry;
        end
    end

    assign out_valid = valid_reg;
    assign out_rot   = rot_reg;
    assign out_carry = carry_reg;

endmodule

// File: rtl/core/ppc_rotate.sv
// Clamp and unfold of sine and cosine, translation rotation, rounding and saturation.
module ppc_rotate (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic signed [ppc_pkg::ROT_W-1:0] in_x,
    input  logic signed [ppc_pkg::ROT_W-1:0] in_y,
    input  ppc_pkg::ppc_carry_t              in_carry,
    output logic                             out_valid,
    output ppc_pkg::ppc_result_t             out_res
);

    // Stage 1: clamped and unfolded cosine and sine.
    logic                v1_reg;
    logic signed [31:0]  c1_reg, s1_reg;
    logic signed [31:0]  c1_next, s1_next;
    ppc_pkg::ppc_carry_t k1_reg;

    // Stage 2: the four products.
    logic                v2_reg;
    logic signed [63:0]  p_cx_reg, p_sy_reg, p_sx_reg, p_cy_reg;
    logic signed [31:0]  c2_reg, s2_reg;
    ppc_pkg::ppc_carry_t k2_reg;

    // Stage 3: rounded sums of products, still at Q30 scale.
    logic                v3_reg;
    logic signed [63:0]  acc_rx_reg, acc_ry_reg, acc_jx_reg;
    logic signed [31:0]  c3_reg, s3_reg;
    ppc_pkg::ppc_carry_t k3_reg;

    logic signed [ppc_pkg::ROT_W-1:0] cx_clamp, sy_clamp;
    logic signed [33:0] rx, ry, jx, jy;

    always_comb
    begin
        if (in_x > ppc_pkg::Q30_ONE) begin
            cx_clamp = ppc_pkg::Q30_ONE;
        end
        else if (in_x < -ppc_pkg::Q30_ONE) begin
            cx_clamp = -ppc_pkg::Q30_ONE;
        end
        else begin
            cx_clamp = in_x;
        end
        if (in_y > ppc_pkg::Q30_ONE) begin
            sy_clamp = ppc_pkg::Q30_ONE;
        end
        else if (in_y < -ppc_pkg::Q30_ONE) begin
            sy_clamp = -ppc_pkg::Q30_ONE;
        end
        else begin
            sy_clamp = in_y;
        end
        if (in_carry.flip) begin
            c1_next = 32'(-cx_clamp);
            s1_next = 32'(-sy_clamp);
        end
        else begin
            c1_next = 32'(cx_clamp);
            s1_next = 32'(sy_clamp);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            c1_reg     <= c1_next;
            s1_reg     <= s1_next;
            k1_reg     <= in_carry;

            p_cx_reg   <= c1_reg * k1_reg.step_x;
            p_sy_reg   <= s1_reg * k1_reg.step_y;
            p_sx_reg   <= s1_reg * k1_reg.step_x;
            p_cy_reg   <= c1_reg * k1_reg.step_y;
            c2_reg     <= c1_reg;
            s2_reg     <= s1_reg;
            k2_reg     <= k1_reg;

            // The x heading Jacobian rounds the negated sum on its own.
            acc_rx_reg <= p_cx_reg - p_sy_reg + ppc_pkg::ROUND_HALF;
            acc_ry_reg <= p_sx_reg + p_cy_reg + ppc_pkg::ROUND_HALF;
            acc_jx_reg <= ppc_pkg::ROUND_HALF - p_sx_reg - p_cy_reg;
            c3_reg     <= c2_reg;
            s3_reg     <= s2_reg;
            k3_reg     <= k2_reg;
        end
    end

    always_comb
    begin
        rx = 34'(acc_rx_reg >>> 30);
        ry = 34'(acc_ry_reg >>> 30);
        jx = 34'(acc_jx_reg >>> 30);
        jy = rx;
        out_res.sum_x         = ppc_pkg::sat32(35'(k3_reg.base_x) + 35'(rx));
        out_res.sum_y         = ppc_pkg::sat32(35'(k3_reg.base_y) + 35'(ry));
        out_res.sum_heading   = k3_reg.heading;
        out_res.jac_x_heading = ppc_pkg::sat32(35'(jx));
        out_res.jac_y_heading = ppc_pkg::sat32(35'(jy));
        out_res.cos_base      = c3_reg;
        out_res.sin_base      = s3_reg;
    end

    assign out_valid = v3_reg;

endmodule
